// ===== rtl/core/mst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants for the multitouch slot tracker.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RPT_W       = $clog2(SLOT_COUNT + 1);
    localparam int N_W         = $clog2(MAX_RESULTS + 1);
    localparam int CFG_W       = 5;

    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_END    = 1'b1;

    typedef enum logic [1:0] {
        PHASE_DOWN = 2'd0,
        PHASE_MOVE = 2'd1,
        PHASE_UP   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LIFT,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic        func;
        logic [31:0] finger_id;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
    } in_req_t;

    typedef struct packed {
        logic [3:0]  slot_index;
        logic [31:0] raw_finger_id;
        logic [15:0] x_out;
        logic [15:0] y_out;
        logic [1:0]  phase;
        logic        any_down;
        logic        last_of_frame;
    } out_rsp_t;

    // command from the sequencer to the slot store
    typedef struct packed {
        logic             wr_en;
        logic             alloc;
        logic [IDX_W-1:0] wr_idx;
        logic [31:0]      raw_id;
        logic [15:0]      x;
        logic [15:0]      y;
        logic             lift;
        logic             clear;
    } store_cmd_t;

    typedef struct packed {
        logic        used;
        logic        is_new;
        logic        lifted;
        logic [31:0] raw_id;
        logic [15:0] x;
        logic [15:0] y;
    } store_rd_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] used_vec;
        logic                  any_down;
    } store_stat_t;

endpackage

// ===== rtl/core/multitouch_slot_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_top
// Maps raw finger ids to stable slots and reports the slots at end of frame.
// ----------------------------------------------------------------------------
//  channel | signals                     | carries
//  --------+-----------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data | finger report or end of frame
//  out     | out_valid, out_ready, out_data | slot entries at end of frame
//  cfg     | cfg_we, cfg_data            | max_reported, reset value 16
//
//  a finger report after acceptance compares one slot per cycle on the
//  shared id comparator, stopping at a match; a report past the frame
//  limit is dropped at acceptance and the block stays idle
//  end of frame does lift marking, walks the slots one a cycle through the
//  store read port unless out_ready stalls an entry, stops at the cap, then releases
//  in_ready is low while a request is in progress; out has its own register
//  reset clears all slot flags and the frame report count
// ----------------------------------------------------------------------------
module multitouch_slot_tracker_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mst_pkg::in_req_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mst_pkg::out_rsp_t           out_data,
    input  logic                        cfg_we,
    input  logic [mst_pkg::CFG_W-1:0]   cfg_data
);

    mst_pkg::state_t              state_reg,      state_next;
    logic [mst_pkg::IDX_W-1:0]    idx_reg,        idx_next;
    logic                         free_found_reg, free_found_next;
    logic [mst_pkg::IDX_W-1:0]    free_idx_reg,   free_idx_next;
    mst_pkg::in_req_t             req_reg,        req_next;
    logic [mst_pkg::RPT_W-1:0]    rpt_cnt_reg,    rpt_cnt_next;
    logic [mst_pkg::N_W-1:0]      n_reg,          n_next;
    logic [mst_pkg::CFG_W-1:0]    max_rep_reg;
    logic                         out_valid_reg,  out_valid_next;
    mst_pkg::out_rsp_t            out_data_reg,   out_data_next;

    mst_pkg::store_cmd_t          cmd;
    mst_pkg::store_rd_t           rd;
    mst_pkg::store_stat_t         stat;

    logic [mst_pkg::N_W-1:0]      cap;
    logic                         in_acc;
    logic                         out_free;
    logic                         idx_last;
    logic                         later_used;
    logic                         id_hit;

    mst_slot_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_idx  (idx_reg),
        .mem_idx (idx_next),
        .rd      (rd),
        .stat    (stat)
    );

    assign in_ready = (state_reg == mst_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign idx_last = (idx_reg == mst_pkg::IDX_W'(mst_pkg::SLOT_COUNT - 1));
    assign id_hit   = rd.used && (rd.raw_id == req_reg.finger_id);

    assign cap = (max_rep_reg > mst_pkg::CFG_W'(mst_pkg::MAX_RESULTS))
               ? mst_pkg::N_W'(mst_pkg::MAX_RESULTS)
               : mst_pkg::N_W'(max_rep_reg);

    // any used slot above the one being looked at
    always_comb
    begin
        later_used = 1'b0;
        for (int i = 0; i < mst_pkg::SLOT_COUNT; i++)
        begin
            if (stat.used_vec[i] && (mst_pkg::IDX_W'(i) > idx_reg))
            begin
                later_used = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        req_next        = req_reg;
        rpt_cnt_next    = rpt_cnt_reg;
        n_next          = n_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd             = '0;
        cmd.raw_id      = req_reg.finger_id;
        cmd.x           = req_reg.x_pos;
        cmd.y           = req_reg.y_pos;
        cmd.wr_idx      = idx_reg;

        case (state_reg)
            mst_pkg::ST_IDLE:
            begin
                idx_next        = '0;
                free_found_next = 1'b0;
                n_next          = '0;
                if (in_acc)
                begin
                    req_next = in_data;
                    if (in_data.func == mst_pkg::FUNC_END)
                    begin
                        state_next = mst_pkg::ST_LIFT;
                    end
                    else if (rpt_cnt_reg < mst_pkg::RPT_W'(mst_pkg::SLOT_COUNT))
                    begin
                        rpt_cnt_next = rpt_cnt_reg + 1'b1;
                        state_next   = mst_pkg::ST_SCAN;
                    end
                end
            end

            mst_pkg::ST_SCAN:
            begin
                if (!rd.used && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (id_hit)
                begin
                    cmd.wr_en  = 1'b1;
                    state_next = mst_pkg::ST_IDLE;
                end
                else if (idx_last)
                begin
                    // new finger takes the lowest free slot, or is dropped
                    if (free_found_reg || !rd.used)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.alloc  = 1'b1;
                        cmd.wr_idx = free_found_reg ? free_idx_reg : idx_reg;
                    end
                    state_next = mst_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            mst_pkg::ST_LIFT:
            begin
                cmd.lift   = 1'b1;
                state_next = mst_pkg::ST_EMIT;
            end

            mst_pkg::ST_EMIT:
            begin
                if (n_reg == cap)
                begin
                    state_next = mst_pkg::ST_CLEAR;
                end
                else if (!rd.used || out_free)
                begin
                    if (rd.used)
                    begin
                        out_valid_next              = 1'b1;
                        out_data_next.slot_index    = 4'(idx_reg);
                        out_data_next.raw_finger_id = rd.raw_id;
                        out_data_next.x_out         = rd.x;
                        out_data_next.y_out         = rd.y;
                        out_data_next.phase         = rd.lifted ? mst_pkg::PHASE_UP
                                                    : (rd.is_new ? mst_pkg::PHASE_DOWN
                                                                 : mst_pkg::PHASE_MOVE);
                        out_data_next.any_down      = stat.any_down;
                        out_data_next.last_of_frame = ((n_reg + 1'b1) == cap) || !later_used;
                        n_next                      = n_reg + 1'b1;
                    end
                    if (idx_last)
                    begin
                        state_next = mst_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            mst_pkg::ST_CLEAR:
            begin
                cmd.clear    = 1'b1;
                rpt_cnt_next = '0;
                state_next   = mst_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = mst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mst_pkg::ST_IDLE;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            rpt_cnt_reg    <= '0;
            n_reg          <= '0;
            max_rep_reg    <= mst_pkg::CFG_W'(mst_pkg::MAX_RESULTS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            rpt_cnt_reg    <= rpt_cnt_next;
            n_reg          <= n_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                max_rep_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/mst_slot_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_slot_store
// Per-slot finger id, coordinates and frame flags, read at one slot a cycle.
// ----------------------------------------------------------------------------
module mst_slot_store
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mst_pkg::store_cmd_t           cmd,
    input  logic [mst_pkg::IDX_W-1:0]     rd_idx,
    input  logic [mst_pkg::IDX_W-1:0]     mem_idx,
    output mst_pkg::store_rd_t            rd,
    output mst_pkg::store_stat_t          stat
);

    logic [31:0] raw_id_mem [mst_pkg::SLOT_COUNT];
    logic [15:0] x_mem      [mst_pkg::SLOT_COUNT];
    logic [15:0] y_mem      [mst_pkg::SLOT_COUNT];

    logic [31:0] raw_id_rd_reg;
    logic [15:0] x_rd_reg;
    logic [15:0] y_rd_reg;

    logic [mst_pkg::SLOT_COUNT-1:0] used_reg,   used_next;
    logic [mst_pkg::SLOT_COUNT-1:0] seen_reg,   seen_next;
    logic [mst_pkg::SLOT_COUNT-1:0] new_reg,    new_next;
    logic [mst_pkg::SLOT_COUNT-1:0] lifted_reg, lifted_next;

    // payload is always written on allocation before it can be read
    // mem_idx is the slot the sequencer looks at next cycle, so the registered
    // read lines up with rd_idx
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            x_mem[cmd.wr_idx] <= cmd.x;
            y_mem[cmd.wr_idx] <= cmd.y;
            if (cmd.alloc)
            begin
                raw_id_mem[cmd.wr_idx] <= cmd.raw_id;
            end
        end
        raw_id_rd_reg <= raw_id_mem[mem_idx];
        x_rd_reg      <= x_mem[mem_idx];
        y_rd_reg      <= y_mem[mem_idx];
    end

    always_comb
    begin
        used_next   = used_reg;
        seen_next   = seen_reg;
        new_next    = new_reg;
        lifted_next = lifted_reg;
        if (cmd.wr_en)
        begin
            seen_next[cmd.wr_idx] = 1'b1;
            if (cmd.alloc)
            begin
                used_next[cmd.wr_idx] = 1'b1;
                new_next[cmd.wr_idx]  = 1'b1;
            end
        end
        if (cmd.lift)
        begin
            lifted_next = lifted_reg | (used_reg & ~seen_reg);
        end
        if (cmd.clear)
        begin
            used_next   = used_reg & ~lifted_reg;
            lifted_next = '0;
            seen_next   = '0;
            new_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            seen_reg   <= '0;
            new_reg    <= '0;
            lifted_reg <= '0;
        end
        else
        begin
            used_reg   <= used_next;
            seen_reg   <= seen_next;
            new_reg    <= new_next;
            lifted_reg <= lifted_next;
        end
    end

    assign rd.used   = used_reg[rd_idx];
    assign rd.is_new = new_reg[rd_idx];
    assign rd.lifted = lifted_reg[rd_idx];
    assign rd.raw_id = raw_id_rd_reg;
    assign rd.x      = x_rd_reg;
    assign rd.y      = y_rd_reg;

    assign stat.used_vec = used_reg;
    assign stat.any_down = |(used_reg & ~lifted_reg);

endmodule

// ===== rtl/core/mst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks for the multitouch slot tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mst_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  mst_pkg::in_req_t            in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  mst_pkg::out_rsp_t           out_data
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // end of frame always keeps the block busy for the slot walk
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.func == mst_pkg::FUNC_END) |=> !in_ready)
        else $error("ready high right after end of frame");

    // results only appear while an end of frame is being worked on
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.phase == mst_pkg::PHASE_DOWN) ||
                      (out_data.phase == mst_pkg::PHASE_MOVE) ||
                      (out_data.phase == mst_pkg::PHASE_UP))
        else $error("bad phase code");

endmodule

bind multitouch_slot_tracker_top mst_checker u_mst_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multitouch slot tracker. Finger reports and
// end-of-frame requests go in through the valid/ready channel. A slot table
// kept in step with the block predicts each frame's slot entries, and every
// entry the block returns is checked against the oldest prediction. Frames
// are mostly well formed with random ids and coordinates. Some frames carry
// more reports than there are slots, and some are loose reports with no end.
// Both sides stall at random, and the emission cap is changed between runs
// while the block is idle.
// ----------------------------------------------------------------------------
class slot_report_board;

    logic                slot_busy   [mst_pkg::SLOT_COUNT];
    logic [31:0]         slot_finger [mst_pkg::SLOT_COUNT];
    logic [15:0]         slot_xpos   [mst_pkg::SLOT_COUNT];
    logic [15:0]         slot_ypos   [mst_pkg::SLOT_COUNT];
    logic                slot_hit    [mst_pkg::SLOT_COUNT];
    logic                slot_fresh  [mst_pkg::SLOT_COUNT];
    logic                slot_gone   [mst_pkg::SLOT_COUNT];
    int unsigned         frame_reports;
    logic [4:0]          report_cap;
    mst_pkg::out_rsp_t   pending_entries[$];
    int                  mismatches;

    function new();
        for (int i = 0; i < mst_pkg::SLOT_COUNT; i++)
        begin
            slot_busy[i]   = 1'b0;
            slot_finger[i] = '0;
            slot_xpos[i]   = '0;
            slot_ypos[i]   = '0;
            slot_hit[i]    = 1'b0;
            slot_fresh[i]  = 1'b0;
            slot_gone[i]   = 1'b0;
        end
        frame_reports = 0;
        report_cap    = 5'd16;
        mismatches    = 0;
    endfunction

    function void set_cap(logic [4:0] value);
        report_cap = value;
    endfunction

    function int pending();
        return pending_entries.size();
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function string describe(mst_pkg::out_rsp_t e);
        return $sformatf("slot %0d id %h x %h y %h phase %0d down %b last %b",
                         e.slot_index, e.raw_finger_id, e.x_out, e.y_out,
                         e.phase, e.any_down, e.last_of_frame);
    endfunction

    function void note_request(mst_pkg::in_req_t req);
        int                slot;
        int                limit;
        int                emitted;
        logic              down;
        mst_pkg::out_rsp_t e;
        if (req.func == mst_pkg::FUNC_REPORT)
        begin
            // beyond a full frame of reports the request is dropped
            if (frame_reports >= mst_pkg::SLOT_COUNT)
                return;
            frame_reports++;
            slot = -1;
            for (int i = 0; i < mst_pkg::SLOT_COUNT; i++)
                if (slot < 0 && slot_busy[i] && slot_finger[i] == req.finger_id)
                    slot = i;
            if (slot < 0)
            begin
                for (int i = 0; i < mst_pkg::SLOT_COUNT; i++)
                    if (slot < 0 && !slot_busy[i])
                        slot = i;
                if (slot < 0)
                    return;
                slot_busy[slot]   = 1'b1;
                slot_finger[slot] = req.finger_id;
                slot_fresh[slot]  = 1'b1;
            end
            slot_xpos[slot] = req.x_pos;
            slot_ypos[slot] = req.y_pos;
            slot_hit[slot]  = 1'b1;
        end
        else
        begin
            limit   = (int'(report_cap) > mst_pkg::MAX_RESULTS) ? mst_pkg::MAX_RESULTS
                                                                 : int'(report_cap);
            emitted = 0;
            down    = 1'b0;
            for (int i = 0; i < mst_pkg::SLOT_COUNT; i++)
                if (slot_busy[i] && !slot_hit[i])
                    slot_gone[i] = 1'b1;
            for (int i = 0; i < mst_pkg::SLOT_COUNT; i++)
                if (slot_busy[i] && !slot_gone[i])
                    down = 1'b1;
            for (int i = 0; i < mst_pkg::SLOT_COUNT; i++)
            begin
                if (slot_busy[i] && emitted < limit)
                begin
                    e.slot_index    = i[3:0];
                    e.raw_finger_id = slot_finger[i];
                    e.x_out         = slot_xpos[i];
                    e.y_out         = slot_ypos[i];
                    e.phase         = slot_gone[i] ? mst_pkg::PHASE_UP :
                                      (slot_fresh[i] ? mst_pkg::PHASE_DOWN
                                                     : mst_pkg::PHASE_MOVE);
                    e.any_down      = down;
                    e.last_of_frame = 1'b0;
                    pending_entries.push_back(e);
                    emitted++;
                end
            end
            if (emitted > 0)
            begin
                e = pending_entries.pop_back();
                e.last_of_frame = 1'b1;
                pending_entries.push_back(e);
            end
            for (int i = 0; i < mst_pkg::SLOT_COUNT; i++)
            begin
                if (slot_gone[i])
                begin
                    slot_busy[i]   = 1'b0;
                    slot_finger[i] = '0;
                    slot_xpos[i]   = '0;
                    slot_ypos[i]   = '0;
                    slot_gone[i]   = 1'b0;
                end
                slot_hit[i]   = 1'b0;
                slot_fresh[i] = 1'b0;
            end
            frame_reports = 0;
        end
    endfunction

    function void check_entry(mst_pkg::out_rsp_t got);
        mst_pkg::out_rsp_t want;
        if (pending_entries.size() == 0)
        begin
            flag({"entry with none expected: ", describe(got)});
            return;
        end
        want = pending_entries.pop_front();
        if (got.slot_index !== want.slot_index || got.raw_finger_id !== want.raw_finger_id ||
            got.x_out !== want.x_out || got.y_out !== want.y_out ||
            got.phase !== want.phase || got.any_down !== want.any_down ||
            got.last_of_frame !== want.last_of_frame)
            flag({"expected ", describe(want), " got ", describe(got)});
    endfunction

endclass

module tb;

    localparam int SETTLE     = 3 * mst_pkg::SLOT_COUNT;
    localparam int LIMIT      = 200000;
    localparam int CHUNKS     = 8;
    localparam int CHUNK_SIZE = 12;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    mst_pkg::in_req_t          in_data  = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    mst_pkg::out_rsp_t         out_data;
    logic                      cfg_we   = 1'b0;
    logic [mst_pkg::CFG_W-1:0] cfg_data = '0;

    slot_report_board    board;
    int                  cycle_count   = 0;
    int                  send_idle     = 0;
    int                  take_idle     = 0;
    int                  sent_items    = 0;
    int                  open_reports  = 0;
    logic [31:0]         held_ids[$];

    multitouch_slot_tracker_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: check what was taken at this edge, then pick next ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_entry(out_data);
            out_ready <= ($urandom_range(99) >= take_idle);
        end
    end

    task automatic send_request(mst_pkg::in_req_t req);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(req);
        if (req.func == mst_pkg::FUNC_END || open_reports < mst_pkg::SLOT_COUNT)
            sent_items++;
        if (req.func == mst_pkg::FUNC_END)
            open_reports = 0;
        else
            open_reports++;
    endtask

    task automatic send_finger(logic [31:0] id, logic [15:0] x, logic [15:0] y);
        mst_pkg::in_req_t req;
        req.func      = mst_pkg::FUNC_REPORT;
        req.finger_id = id;
        req.x_pos     = x;
        req.y_pos     = y;
        send_request(req);
    endtask

    task automatic send_end();
        mst_pkg::in_req_t req;
        req.func      = mst_pkg::FUNC_END;
        req.finger_id = $urandom;
        req.x_pos     = 16'($urandom);
        req.y_pos     = 16'($urandom);
        send_request(req);
    endtask

    // block must be idle: all entries back and any lone report finished
    task automatic set_cap(logic [mst_pkg::CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.set_cap(value);
    endtask

    function automatic logic [31:0] fresh_id();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 32'h0000_0000;
        if (pick == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // fingers held from the last frame mostly stay, a few lift, a few land
    task automatic play_frame();
        logic [31:0] next_ids[$];
        logic [31:0] id;
        int          landing;
        foreach (held_ids[k])
        begin
            if ($urandom_range(99) < 80)
            begin
                send_finger(held_ids[k], 16'($urandom), 16'($urandom));
                next_ids.push_back(held_ids[k]);
                if ($urandom_range(99) < 10)
                    send_finger(held_ids[k], 16'($urandom), 16'($urandom));
            end
        end
        landing = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        repeat (landing)
        begin
            id = fresh_id();
            send_finger(id, 16'($urandom), 16'($urandom));
            next_ids.push_back(id);
        end
        send_end();
        while (next_ids.size() > 20)
            void'(next_ids.pop_front());
        held_ids = next_ids;
    endtask

    // more reports than slots: the tail of the frame is dropped
    task automatic flood_frame();
        logic [31:0] next_ids[$];
        logic [31:0] id;
        repeat ($urandom_range(17, 20))
        begin
            if (held_ids.size() > 0 && $urandom_range(1) == 1)
                id = held_ids[$urandom_range(held_ids.size() - 1)];
            else
                id = fresh_id();
            send_finger(id, 16'($urandom), 16'($urandom));
            next_ids.push_back(id);
        end
        send_end();
        while (next_ids.size() > 20)
            void'(next_ids.pop_front());
        held_ids = next_ids;
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4))
            send_finger(fresh_id(), 16'($urandom), 16'($urandom));
        if ($urandom_range(1) == 1)
            send_end();
    endtask

    initial
    begin
        logic [mst_pkg::CFG_W-1:0] caps[CHUNKS];
        int                        target;
        int                        pick;
        board = new();
        caps  = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd17, 5'd2, 5'd16, 5'd16};
        caps[6] = mst_pkg::CFG_W'($urandom_range(0, 31));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 14;
        take_idle = 56;
        set_cap(5'd16);

        // extremes, a new pair, a repeat in one frame, a lift, an empty frame
        send_finger(32'h0000_0000, 16'h0000, 16'h0000);
        send_finger(32'hffff_ffff, 16'hffff, 16'hffff);
        send_end();
        send_finger(32'hffff_ffff, 16'h1234, 16'h8001);
        send_finger(32'hffff_ffff, 16'h7ffe, 16'hfffe);
        send_end();
        send_end();
        send_end();
        // seventeen distinct fingers: last one over the frame limit
        held_ids.delete();
        for (int k = 0; k < mst_pkg::SLOT_COUNT + 1; k++)
        begin
            send_finger(32'h1000_0000 + k, 16'($urandom), 16'($urandom));
            held_ids.push_back(32'h1000_0000 + k);
        end
        send_end();

        for (int c = 0; c < CHUNKS; c++)
        begin
            if (c < 3)
            begin
                send_idle = 14;
                take_idle = 56;
            end
            else if (c < 6)
            begin
                send_idle = 56;
                take_idle = 14;
            end
            else
            begin
                send_idle = 0;
                take_idle = 0;
            end
            set_cap(caps[c]);
            target = sent_items + CHUNK_SIZE;
            while (sent_items < target)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    play_frame();
                else if (pick < 85)
                    flood_frame();
                else
                    noise_burst();
            end
        end
        send_end();

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mst_pkg.sv
rtl/core/mst_slot_store.sv
rtl/core/multitouch_slot_tracker_top.sv
rtl/core/mst_checker.sv
tb/tb.sv
